>>> sv/gbs_pkg.sv
package gbs_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam logic [15:0] THR_RESET = 16'd29491;

    // One stored box: 60 bits.
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [13:0]        width;
        logic [13:0]        height;
    } t_box;

    // Token that walks the cell row. inter/uni belong to the previous cell's
    // comparison and are only meaningful when pend is set.
    typedef struct packed {
        logic               valid;
        logic               flag;
        logic               pend;
        t_box               box;
        logic [27:0]        area;
        logic [28:0]        inter;
        logic signed [30:0] uni;
    } t_link;

    // Overlap test: union not positive, or inter * 2^16 > thr * union.
    function automatic logic f_exceeds(input logic [28:0] inter,
                                       input logic signed [30:0] uni,
                                       input logic [15:0] thr);
        logic [45:0] lhs;
        logic [45:0] rhs;
        logic        non_pos;
        lhs     = {1'b0, inter, 16'd0};
        rhs     = thr * uni[29:0];
        non_pos = uni[30] || (uni == 31'sd0);
        return non_pos || (lhs > rhs);
    endfunction

endpackage

>>> sv/gbs_box_if.sv
interface gbs_box_if;
    import gbs_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [13:0]        box_width;
    logic [13:0]        box_height;
    logic               frame_end;

    modport source (output valid, box_left, box_top, box_width, box_height, frame_end,
                    input ready);
    modport sink (input valid, box_left, box_top, box_width, box_height, frame_end,
                  output ready);
endinterface

>>> sv/gbs_res_if.sv
interface gbs_res_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [15:0] box_number;
    logic        store_overflow;
    logic        frame_done;

    modport source (output valid, keep, box_number, store_overflow, frame_done,
                    input ready);
    modport sink (input valid, keep, box_number, store_overflow, frame_done,
                  output ready);
endinterface

>>> sv/gbs_cell.sv
module gbs_cell
    import gbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_thr,
    input  logic        i_active,
    input  logic        i_wr_en,
    input  t_box        i_wr_box,
    input  logic [27:0] i_wr_area,
    input  t_link       i_link,
    output t_link       o_link
);

    t_box               r_box;
    logic [27:0]        r_area;
    logic               r_valid;
    t_link              r_link;
    t_link              n_link;

    logic signed [17:0] w_ra, w_rb, w_la, w_lb, w_minr, w_maxl, w_dx;
    logic signed [17:0] w_ba, w_bb, w_ta, w_tb, w_minb, w_maxt, w_dy;
    logic [14:0]        w_cx, w_cy;
    logic [29:0]        w_prod;
    logic [28:0]        w_inter;

    // Intersection of the passing box with the box held here.
    always_comb begin
        w_la   = 18'(i_link.box.left);
        w_lb   = 18'(r_box.left);
        w_ra   = w_la + 18'(signed'({1'b0, i_link.box.width}));
        w_rb   = w_lb + 18'(signed'({1'b0, r_box.width}));
        w_minr = (w_ra < w_rb) ? w_ra : w_rb;
        w_maxl = (w_la > w_lb) ? w_la : w_lb;
        w_dx   = w_minr - w_maxl + 18'sd1;

        w_ta   = 18'(i_link.box.top);
        w_tb   = 18'(r_box.top);
        w_ba   = w_ta + 18'(signed'({1'b0, i_link.box.height}));
        w_bb   = w_tb + 18'(signed'({1'b0, r_box.height}));
        w_minb = (w_ba < w_bb) ? w_ba : w_bb;
        w_maxt = (w_ta > w_tb) ? w_ta : w_tb;
        w_dy   = w_minb - w_maxt + 18'sd1;

        // Clamp at zero; a positive extent never exceeds 16384.
        w_cx    = w_dx[17] ? 15'd0 : w_dx[14:0];
        w_cy    = w_dy[17] ? 15'd0 : w_dy[14:0];
        w_prod  = w_cx * w_cy;
        w_inter = w_prod[28:0];
    end

    // Finish the previous cell's test, start our own.
    always_comb begin
        n_link       = i_link;
        n_link.flag  = i_link.flag
                       | (i_link.pend & f_exceeds(i_link.inter, i_link.uni, i_thr));
        n_link.pend  = i_active;
        n_link.inter = w_inter;
        n_link.uni   = $signed({3'b0, i_link.area}) + $signed({3'b0, r_area})
                       - $signed({2'b0, w_inter});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
        if (i_wr_en) begin
            r_box  <= i_wr_box;
            r_area <= i_wr_area;
        end
    end

    always_comb begin
        o_link       = r_link;
        o_link.valid = r_valid;
    end

endmodule

>>> sv/greedy_box_suppression_core.sv
// Path of a box request: request capture, then the walk through the row of MAX_KEPT compare
// cells, one cell per cycle, then the hold stage and the output register. A new request is
// taken only once the previous box has left the row and the hold stage.
// A waiting result does not block the next request; the next result waits in a hold stage.
// Reset (synchronous, active low): kept count and box counter cleared, threshold to 29491,
// pipeline empty. Stored boxes are not cleared; only entries below the kept count are used.
module greedy_box_suppression_core
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    gbs_box_if.sink     i_box,
    gbs_res_if.source   o_res
);

    localparam int CW = $clog2(MAX_KEPT + 1);

    // Threshold register.
    logic [15:0]  r_thr;

    // Request capture, feeding the first cell.
    logic         r_q_v;
    t_box         r_q_box;
    logic [27:0]  r_q_area;
    logic         r_fend;
    logic         r_run;

    // Finished decision waiting for the output register.
    logic         r_hold;
    logic         r_hold_keep;
    t_box         r_hold_box;
    logic [27:0]  r_hold_area;

    // Frame state.
    logic [CW-1:0] r_count;
    logic [15:0]   r_box_cnt;

    // Output register.
    logic         r_out_v;
    logic         r_out_keep;
    logic [15:0]  r_out_num;
    logic         r_out_ovf;
    logic         r_out_done;

    t_link        w_link [0:MAX_KEPT];
    t_link        w_tail;
    logic         w_accept;
    logic         w_suppress;
    logic         w_move;
    logic         w_full;
    logic         w_store;

    assign i_box.ready = !r_run && !r_hold && !r_q_v;
    assign w_accept    = i_box.valid && i_box.ready;

    assign w_full  = (r_count == CW'(MAX_KEPT));
    assign w_move  = r_hold && (!r_out_v || o_res.ready);
    assign w_store = w_move && r_hold_keep && !w_full;

    // The first cell sees no pending test.
    always_comb begin
        w_link[0]       = '0;
        w_link[0].valid = r_q_v;
        w_link[0].box   = r_q_box;
        w_link[0].area  = r_q_area;
    end

    // Row of compare cells; cell k holds kept box k.
    for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
        gbs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_thr     (r_thr),
            .i_active  (CW'(k) < r_count),
            .i_wr_en   (w_store && (r_count == CW'(k))),
            .i_wr_box  (r_hold_box),
            .i_wr_area (r_hold_area),
            .i_link    (w_link[k]),
            .o_link    (w_link[k+1])
        );
    end

    // Close the test of the last cell.
    assign w_tail     = w_link[MAX_KEPT];
    assign w_suppress = w_tail.flag
                        | (w_tail.pend & f_exceeds(w_tail.inter, w_tail.uni, r_thr));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_q_v     <= 1'b0;
            r_run     <= 1'b0;
            r_hold    <= 1'b0;
            r_count   <= '0;
            r_box_cnt <= '0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_q_v <= w_accept;
            // Hold the run flag until the request leaves the last cell.
            if (w_accept) begin
                r_run <= 1'b1;
            end else if (w_tail.valid) begin
                r_run <= 1'b0;
            end
            if (w_tail.valid) begin
                r_hold <= 1'b1;
            end else if (w_move) begin
                r_hold <= 1'b0;
            end
            // Commit frame state when the result moves to the output.
            if (w_move) begin
                if (r_fend) begin
                    r_count   <= '0;
                    r_box_cnt <= '0;
                end else begin
                    r_box_cnt <= r_box_cnt + 16'd1;
                    if (w_store) begin
                        r_count <= r_count + CW'(1);
                    end
                end
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_box.left   <= i_box.box_left;
            r_q_box.top    <= i_box.box_top;
            r_q_box.width  <= i_box.box_width;
            r_q_box.height <= i_box.box_height;
            r_q_area       <= i_box.box_width * i_box.box_height;
            r_fend         <= i_box.frame_end;
        end
        if (w_tail.valid) begin
            r_hold_keep <= !w_suppress;
            r_hold_box  <= w_tail.box;
            r_hold_area <= w_tail.area;
        end
        if (w_move) begin
            r_out_keep <= r_hold_keep;
            r_out_num  <= r_box_cnt;
            r_out_ovf  <= r_hold_keep && w_full;
            r_out_done <= r_fend;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.keep           = r_out_keep;
    assign o_res.box_number     = r_out_num;
    assign o_res.store_overflow = r_out_ovf;
    assign o_res.frame_done     = r_out_done;

endmodule

>>> sv/gbs_checker.sv
module gbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_keep,
    input logic i_overflow
);

    // A result that is not taken stays.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Only one request in flight: no request right after another.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while one is in flight");

    // Overflow only marks a kept box.
    a_ovf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_keep)
        else $error("overflow without keep");

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_box.valid),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_keep      (o_res.keep),
    .i_overflow  (o_res.store_overflow)
);
